>>> rtl/sadtd_pkg.sv
// package for the 3x3 sad template distance block
// frame geometry, field widths, register indexes, shared types and the template helper
// no dependencies
`default_nettype none

package sadtd_pkg;

   localparam int LINE_WIDTH   = 640;
   localparam int FRAME_HEIGHT = 480;

   localparam int COL_W = $clog2(LINE_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT + 2);

   localparam int ADDR_W     = 6;
   localparam int DATA_W     = 64;
   localparam int WEIGHT_W   = 10;
   localparam int DIST_W     = 15;
   localparam int CELL_SUM_W = 10;
   localparam int CHAN_SUM_W = 12;
   localparam int PROD_W     = 22;
   localparam int TOTAL_W    = 24;
   localparam int TMPL_BYTES = 27;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam logic [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(128);

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_TMPL0  = 3'd0;
   localparam reg_index_type REG_TMPL1  = 3'd1;
   localparam reg_index_type REG_TMPL2  = 3'd2;
   localparam reg_index_type REG_TMPL3  = 3'd3;
   localparam reg_index_type REG_WBLUE  = 3'd4;
   localparam reg_index_type REG_WGREEN = 3'd5;
   localparam reg_index_type REG_WRED   = 3'd6;

   localparam logic [WEIGHT_W-1:0] WBLUE_RESET  = WEIGHT_W'(256);
   localparam logic [WEIGHT_W-1:0] WGREEN_RESET = WEIGHT_W'(307);
   localparam logic [WEIGHT_W-1:0] WRED_RESET   = WEIGHT_W'(205);

   // blue in the low byte
   typedef logic [23:0] pixel_type;
   typedef logic [8*TMPL_BYTES-1:0] template_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   // one window column, top is the oldest row
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic [CELL_SUM_W-1:0] blue;
      logic [CELL_SUM_W-1:0] green;
      logic [CELL_SUM_W-1:0] red;
   } cell_sum_type;

   typedef struct packed {
      logic valid;
      logic mask_first;
      logic mask_last;
      logic last;
   } win_ctrl_type;

   // template column j as a window column, byte (row*3+col)*3+channel
   function automatic column_type tmpl_column(input template_type t, input int j);
      column_type c;
      c.top = {t[((0*3+j)*3+2)*8 +: 8], t[((0*3+j)*3+1)*8 +: 8], t[((0*3+j)*3)*8 +: 8]};
      c.mid = {t[((1*3+j)*3+2)*8 +: 8], t[((1*3+j)*3+1)*8 +: 8], t[((1*3+j)*3)*8 +: 8]};
      c.bot = {t[((2*3+j)*3+2)*8 +: 8], t[((2*3+j)*3+1)*8 +: 8], t[((2*3+j)*3)*8 +: 8]};
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sad_template_distance_3x3.sv
// 3x3 sum-of-absolute-differences template distance over a bgr pixel stream
// input channel (req_*): one pixel item per accepted edge in raster order, a frame
// of LINE_WIDTH x FRAME_HEIGHT pixels followed by LINE_WIDTH+1 padding items that
// flush the last row; frame position follows the item count alone
// result channel (rsp_*): zero or one item per input item; the first LINE_WIDTH+1
// items of a frame give none, each later one gives the distance of the pixel
// LINE_WIDTH+1 items back with the frame's running min and max so far
// configuration: apb-style, 64-bit data, register i at byte address 8*i
// throughput: one item per cycle while results are taken, set by the three window
// cells shifting once per item and one read-ahead line-store access per item
// path: an accepted item is held in the window, then goes through channel sums,
// weighting, and rounding with min/max into the output register
// stall: a held result lets the block take items until the three stages and the
// window each hold a scored item; the input is then stalled in the same cycle
// reset: synchronous, restarts the frame count, clears min/max and all stages,
// restores default weights and a zero template; the line stores need no clearing
// depends on sadtd_pkg, sadtd_csr, sadtd_feed, sadtd_cell, sadtd_score
`default_nettype none

module sad_template_distance_3x3 (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_blue,
   input  wire logic [7:0]                   req_green,
   input  wire logic [7:0]                   req_red,
   input  wire logic                         req_padding,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [sadtd_pkg::DIST_W-1:0]      rsp_distance,
   output logic [sadtd_pkg::DIST_W-1:0]      rsp_frame_min,
   output logic [sadtd_pkg::DIST_W-1:0]      rsp_frame_max,
   output logic                              rsp_last_of_frame,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sadtd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [sadtd_pkg::DATA_W-1:0] pwdata,
   output logic      [sadtd_pkg::DATA_W-1:0] prdata,
   output logic                              pready
);
   import sadtd_pkg::*;

   template_type tmpl;
   weight_type   wt_blue, wt_green, wt_red;
   logic         shift_en, score_ready;
   column_type   enter_col, col2, col1, col0;
   win_ctrl_type win_ctrl;
   cell_sum_type sums0, sums1, sums2;

   sadtd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .tmpl     (tmpl),
      .wt_blue  (wt_blue),
      .wt_green (wt_green),
      .wt_red   (wt_red)
   );

   sadtd_feed u_feed (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_blue    (req_blue),
      .req_green   (req_green),
      .req_red     (req_red),
      .req_padding (req_padding),
      .next_ready  (score_ready),
      .shift_en    (shift_en),
      .enter_col   (enter_col),
      .win_ctrl    (win_ctrl)
   );

   // newest column enters cell 2 and moves toward cell 0
   sadtd_cell u_cell2 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (enter_col),
      .tmpl_col (tmpl_column(tmpl, 2)),
      .mask     (win_ctrl.mask_last),
      .col_out  (col2),
      .sums     (sums2)
   );

   sadtd_cell u_cell1 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (col2),
      .tmpl_col (tmpl_column(tmpl, 1)),
      .mask     (1'b0),
      .col_out  (col1),
      .sums     (sums1)
   );

   sadtd_cell u_cell0 (
      .clock    (clock),
      .shift_en (shift_en),
      .col_in   (col1),
      .tmpl_col (tmpl_column(tmpl, 0)),
      .mask     (win_ctrl.mask_first),
      .col_out  (col0),
      .sums     (sums0)
   );

   sadtd_score u_score (
      .clock             (clock),
      .reset             (reset),
      .in_ctrl           (win_ctrl),
      .sums0             (sums0),
      .sums1             (sums1),
      .sums2             (sums2),
      .wt_blue           (wt_blue),
      .wt_green          (wt_green),
      .wt_red            (wt_red),
      .in_ready          (score_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .rsp_frame_min     (rsp_frame_min),
      .rsp_frame_max     (rsp_frame_max),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   a_min_max_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_min <= rsp_distance) && (rsp_distance <= rsp_frame_max))
      else $error("distance outside frame min/max");

   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (win_ctrl.valid && !score_ready) |=> (win_ctrl.valid && $stable(col0) && $stable(col2)))
      else $error("window item overwritten before it was scored");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_frame) |=>
         (!rsp_valid || ((rsp_frame_min == rsp_distance) && (rsp_frame_max == rsp_distance))))
      else $error("min/max not restarted after end of frame");

endmodule

`default_nettype wire

>>> rtl/sadtd_csr.sv
// configuration registers: template bytes and channel weights
// apb-style write and read port, uses sadtd_pkg
`default_nettype none

module sadtd_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [sadtd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [sadtd_pkg::DATA_W-1:0] pwdata,
   output logic      [sadtd_pkg::DATA_W-1:0] prdata,
   output logic                              pready,
   output sadtd_pkg::template_type           tmpl,
   output sadtd_pkg::weight_type             wt_blue,
   output sadtd_pkg::weight_type             wt_green,
   output sadtd_pkg::weight_type             wt_red
);
   import sadtd_pkg::*;

   template_type  tmpl_ff, tmpl_in;
   weight_type    wblue_ff, wblue_in, wgreen_ff, wgreen_in, wred_ff, wred_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = paddr[ADDR_W-1:3];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      tmpl_in   = tmpl_ff;
      wblue_in  = wblue_ff;
      wgreen_in = wgreen_ff;
      wred_in   = wred_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TMPL0:  tmpl_in[63:0]    = pwdata;
            REG_TMPL1:  tmpl_in[127:64]  = pwdata;
            REG_TMPL2:  tmpl_in[191:128] = pwdata;
            REG_TMPL3:  tmpl_in[215:192] = pwdata[23:0];
            REG_WBLUE:  wblue_in  = pwdata[WEIGHT_W-1:0];
            REG_WGREEN: wgreen_in = pwdata[WEIGHT_W-1:0];
            REG_WRED:   wred_in   = pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmpl_ff   <= '0;
         wblue_ff  <= WBLUE_RESET;
         wgreen_ff <= WGREEN_RESET;
         wred_ff   <= WRED_RESET;
      end else begin
         tmpl_ff   <= tmpl_in;
         wblue_ff  <= wblue_in;
         wgreen_ff <= wgreen_in;
         wred_ff   <= wred_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_TMPL0:  prdata = tmpl_ff[63:0];
         REG_TMPL1:  prdata = tmpl_ff[127:64];
         REG_TMPL2:  prdata = tmpl_ff[191:128];
         REG_TMPL3:  prdata = {40'd0, tmpl_ff[215:192]};
         REG_WBLUE:  prdata = {{(DATA_W-WEIGHT_W){1'b0}}, wblue_ff};
         REG_WGREEN: prdata = {{(DATA_W-WEIGHT_W){1'b0}}, wgreen_ff};
         REG_WRED:   prdata = {{(DATA_W-WEIGHT_W){1'b0}}, wred_ff};
         default:    prdata = '0;
      endcase
   end

   assign tmpl     = tmpl_ff;
   assign wt_blue  = wblue_ff;
   assign wt_green = wgreen_ff;
   assign wt_red   = wred_ff;

endmodule

`default_nettype wire

>>> rtl/sadtd_feed.sv
// input side: raster counters, two line stores with read-ahead, entry masking
// and the control word of the item held in the window; uses sadtd_pkg
`default_nettype none

module sadtd_feed (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_blue,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_red,
   input  wire logic                  req_padding,
   input  wire logic                  next_ready,
   output logic                       shift_en,
   output sadtd_pkg::column_type      enter_col,
   output sadtd_pkg::win_ctrl_type    win_ctrl
);
   import sadtd_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   win_ctrl_type     wctrl_ff, wctrl_in;
   pixel_type        top_rd_ff, mid_rd_ff;
   pixel_type        upper_mem [LINE_WIDTH];
   pixel_type        middle_mem [LINE_WIDTH];

   logic      w_ready, accept, last_item, col_wrap, has_result;
   pixel_type px_eff;

   assign w_ready   = !wctrl_ff.valid || next_ready;
   assign accept    = req_valid && w_ready;
   assign req_stall = !w_ready;
   assign shift_en  = accept;

   assign last_item = (row_ff == ROW_W'(FRAME_HEIGHT + 1)) && (col_ff == '0);
   assign col_wrap  = (col_ff == COL_W'(LINE_WIDTH - 1));
   // centre pixel exists from item LINE_WIDTH+1 on
   assign has_result = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));

   assign px_eff = (!req_padding && (row_ff < ROW_W'(FRAME_HEIGHT))) ?
                   {req_red, req_green, req_blue} : '0;

   // rows above the frame or below it enter as zero
   always_comb begin
      enter_col.top = (row_ff >= ROW_W'(2)) ? top_rd_ff : '0;
      enter_col.mid = ((row_ff >= ROW_W'(1)) && (row_ff <= ROW_W'(FRAME_HEIGHT))) ?
                      mid_rd_ff : '0;
      enter_col.bot = px_eff;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         priority if (last_item) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      wctrl_in = wctrl_ff;
      if (accept) begin
         wctrl_in.valid      = has_result;
         wctrl_in.mask_first = (col_ff == COL_W'(1));
         wctrl_in.mask_last  = (col_ff == '0);
         wctrl_in.last       = last_item;
      end else if (next_ready) begin
         wctrl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         wctrl_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         wctrl_ff <= wctrl_in;
      end
   end

   // the next column is read while the current one is written
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff]  <= mid_rd_ff;
         middle_mem[col_ff] <= px_eff;
         top_rd_ff          <= upper_mem[col_in];
         mid_rd_ff          <= middle_mem[col_in];
      end
   end

   assign win_ctrl = wctrl_ff;

endmodule

`default_nettype wire

>>> rtl/sadtd_cell.sv
// one window column cell: holds three pixels, passes them to its neighbor
// and sums the per-channel absolute differences to its template column; uses sadtd_pkg
`default_nettype none

module sadtd_cell (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  sadtd_pkg::column_type      col_in,
   input  sadtd_pkg::column_type      tmpl_col,
   input  wire logic                  mask,
   output sadtd_pkg::column_type      col_out,
   output sadtd_pkg::cell_sum_type    sums
);
   import sadtd_pkg::*;

   column_type col_ff;

   function automatic logic [CELL_SUM_W-1:0] absdiff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return CELL_SUM_W'(d);
   endfunction

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   pixel_type p [3];
   pixel_type t [3];

   always_comb begin
      // a column outside the frame counts as zero pixels
      p[0] = mask ? '0 : col_ff.top;
      p[1] = mask ? '0 : col_ff.mid;
      p[2] = mask ? '0 : col_ff.bot;
      t[0] = tmpl_col.top;
      t[1] = tmpl_col.mid;
      t[2] = tmpl_col.bot;
      sums = '0;
      for (int i = 0; i < 3; i++) begin
         sums.blue  = sums.blue  + absdiff(p[i][7:0],   t[i][7:0]);
         sums.green = sums.green + absdiff(p[i][15:8],  t[i][15:8]);
         sums.red   = sums.red   + absdiff(p[i][23:16], t[i][23:16]);
      end
   end

   assign col_out = col_ff;

endmodule

`default_nettype wire

>>> rtl/sadtd_score.sv
// scoring pipeline: channel sums, weighting, rounding and running min/max
// three stages with per-stage hand-off, the third being the output register; uses sadtd_pkg
`default_nettype none

module sadtd_score (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  sadtd_pkg::win_ctrl_type            in_ctrl,
   input  sadtd_pkg::cell_sum_type            sums0,
   input  sadtd_pkg::cell_sum_type            sums1,
   input  sadtd_pkg::cell_sum_type            sums2,
   input  sadtd_pkg::weight_type              wt_blue,
   input  sadtd_pkg::weight_type              wt_green,
   input  sadtd_pkg::weight_type              wt_red,
   output logic                               in_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [sadtd_pkg::DIST_W-1:0]  rsp_distance,
   output logic      [sadtd_pkg::DIST_W-1:0]  rsp_frame_min,
   output logic      [sadtd_pkg::DIST_W-1:0]  rsp_frame_max,
   output logic                               rsp_last_of_frame
);
   import sadtd_pkg::*;

   logic                  s1_valid_ff, s1_valid_in, s1_last_ff;
   logic [CHAN_SUM_W-1:0] s1_b_ff, s1_g_ff, s1_r_ff;
   logic                  s2_valid_ff, s2_valid_in, s2_last_ff;
   logic [PROD_W-1:0]     s2_b_ff, s2_g_ff, s2_r_ff;
   logic                  s3_valid_ff, s3_valid_in, s3_last_ff;
   logic [DIST_W-1:0]     s3_dist_ff, s3_min_ff, s3_max_ff;
   logic [DIST_W-1:0]     min_ff, min_in, max_ff, max_in;

   logic s1_ready, s2_ready, s3_ready, load1, load2, load3;
   logic [TOTAL_W-1:0] total;
   logic [DIST_W:0]    dist_wide;
   logic [DIST_W-1:0]  cur_dist, new_min, new_max;

   assign s3_ready = !s3_valid_ff || !rsp_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign load1 = in_ctrl.valid && s1_ready;
   assign load2 = s1_valid_ff && s2_ready;
   assign load3 = s2_valid_ff && s3_ready;

   assign s1_valid_in = load1 ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = load2 ? 1'b1 : (s3_ready ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = load3 ? 1'b1 : (!rsp_stall ? 1'b0 : s3_valid_ff);

   // weighted sum, rounded half up, then dropped to whole units
   assign total = TOTAL_W'(s2_b_ff) + TOTAL_W'(s2_g_ff) + TOTAL_W'(s2_r_ff) + ROUND_HALF;
   assign dist_wide = total[TOTAL_W-1:8];
   assign cur_dist  = dist_wide[DIST_W] ? DIST_MAX : dist_wide[DIST_W-1:0];
   assign new_min   = (cur_dist < min_ff) ? cur_dist : min_ff;
   assign new_max   = (cur_dist > max_ff) ? cur_dist : max_ff;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (load3) begin
         min_in = s2_last_ff ? DIST_MAX : new_min;
         max_in = s2_last_ff ? '0 : new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         min_ff      <= DIST_MAX;
         max_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_b_ff    <= CHAN_SUM_W'(sums0.blue)  + CHAN_SUM_W'(sums1.blue)  + CHAN_SUM_W'(sums2.blue);
         s1_g_ff    <= CHAN_SUM_W'(sums0.green) + CHAN_SUM_W'(sums1.green) + CHAN_SUM_W'(sums2.green);
         s1_r_ff    <= CHAN_SUM_W'(sums0.red)   + CHAN_SUM_W'(sums1.red)   + CHAN_SUM_W'(sums2.red);
         s1_last_ff <= in_ctrl.last;
      end
      if (load2) begin
         s2_b_ff    <= PROD_W'(wt_blue)  * PROD_W'(s1_b_ff);
         s2_g_ff    <= PROD_W'(wt_green) * PROD_W'(s1_g_ff);
         s2_r_ff    <= PROD_W'(wt_red)   * PROD_W'(s1_r_ff);
         s2_last_ff <= s1_last_ff;
      end
      if (load3) begin
         s3_dist_ff <= cur_dist;
         s3_min_ff  <= new_min;
         s3_max_ff  <= new_max;
         s3_last_ff <= s2_last_ff;
      end
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_distance      = s3_dist_ff;
   assign rsp_frame_min     = s3_min_ff;
   assign rsp_frame_max     = s3_max_ff;
   assign rsp_last_of_frame = s3_last_ff;

endmodule

`default_nettype wire

>>> dv/sadtd_scoreboard_pkg.sv
// scoreboard for the 3x3 sad template distance block: line stores, window, weighting
// and per-frame min/max kept in step with every accepted pixel item
// depends on sadtd_pkg for frame geometry, widths and register indexes
package sadtd_scoreboard_pkg;
   import sadtd_pkg::*;

   localparam int unsigned PIXEL_ITEMS = LINE_WIDTH * FRAME_HEIGHT;
   localparam int unsigned FRAME_ITEMS = PIXEL_ITEMS + LINE_WIDTH + 1;
   localparam int unsigned DIST_CEIL   = (1 << DIST_W) - 1;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [DIST_W-1:0] frame_min;
      logic [DIST_W-1:0] frame_max;
      logic              last_of_frame;
   } distance_result_type;

   class sad_distance_scoreboard;
      logic [7:0]          tmpl_byte [TMPL_BYTES];
      weight_type          weight_blue;
      weight_type          weight_green;
      weight_type          weight_red;
      logic [DATA_W-1:0]   reg_shadow [REG_WRED+1];
      pixel_type           upper_line [LINE_WIDTH];
      pixel_type           middle_line [LINE_WIDTH];
      pixel_type           window [3][3];   // [column][row], column 2 newest
      int unsigned         position;
      logic [DIST_W-1:0]   low_mark;
      logic [DIST_W-1:0]   high_mark;
      distance_result_type distance_queue [$];
      int unsigned         failures;
      int unsigned         results_seen;

      function new();
         foreach (tmpl_byte[k]) tmpl_byte[k] = '0;
         foreach (reg_shadow[k]) reg_shadow[k] = '0;
         foreach (upper_line[k]) upper_line[k] = '0;
         foreach (middle_line[k]) middle_line[k] = '0;
         foreach (window[j, i]) window[j][i] = '0;
         weight_blue  = WBLUE_RESET;
         weight_green = WGREEN_RESET;
         weight_red   = WRED_RESET;
         reg_shadow[REG_WBLUE]  = DATA_W'(WBLUE_RESET);
         reg_shadow[REG_WGREEN] = DATA_W'(WGREEN_RESET);
         reg_shadow[REG_WRED]   = DATA_W'(WRED_RESET);
         position     = 0;
         low_mark     = '1;
         high_mark    = '0;
         failures     = 0;
         results_seen = 0;
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= MAX_REPORTS) $display("%s", what);
      endfunction

      function void write_register(reg_index_type idx, logic [DATA_W-1:0] value);
         int count;
         case (idx)
            REG_TMPL0, REG_TMPL1, REG_TMPL2, REG_TMPL3: begin
               count = (idx == REG_TMPL3) ? 3 : 8;
               reg_shadow[idx] = '0;
               for (int k = 0; k < count; k++) begin
                  tmpl_byte[8 * int'(idx) + k] = value[8*k +: 8];
                  reg_shadow[idx][8*k +: 8] = value[8*k +: 8];
               end
            end
            REG_WBLUE: begin
               weight_blue = value[WEIGHT_W-1:0];
               reg_shadow[idx] = DATA_W'(weight_blue);
            end
            REG_WGREEN: begin
               weight_green = value[WEIGHT_W-1:0];
               reg_shadow[idx] = DATA_W'(weight_green);
            end
            REG_WRED: begin
               weight_red = value[WEIGHT_W-1:0];
               reg_shadow[idx] = DATA_W'(weight_red);
            end
            default: ;
         endcase
      endfunction

      function logic [DATA_W-1:0] register_value(reg_index_type idx);
         return reg_shadow[idx];
      endfunction

      function int unsigned pending();
         return distance_queue.size();
      endfunction

      // one pixel item in: shift stores and window, score the centre pixel
      function void note_pixel(logic [7:0] blue, logic [7:0] green, logic [7:0] red,
                               logic padding);
         int unsigned         n, row, col, score;
         int unsigned         sum [3];
         int                  cr, cc, r, c, v, t;
         pixel_type           px, top, mid, p;
         distance_result_type res;

         n   = position;
         row = n / LINE_WIDTH;
         col = n % LINE_WIDTH;
         px  = '0;
         if (!padding && n < PIXEL_ITEMS) px = {red, green, blue};

         top = upper_line[col];
         mid = middle_line[col];
         upper_line[col]  = mid;
         middle_line[col] = px;
         for (int i = 0; i < 3; i++) begin
            window[0][i] = window[1][i];
            window[1][i] = window[2][i];
         end
         window[2][0] = top;
         window[2][1] = mid;
         window[2][2] = px;

         position = (n + 1 >= FRAME_ITEMS) ? 0 : n + 1;
         if (n < LINE_WIDTH + 1) return;

         // centre sits one row and one column back, wrapping to the previous row
         if (col >= 1) begin
            cr = int'(row) - 1;
            cc = int'(col) - 1;
         end else begin
            cr = int'(row) - 2;
            cc = LINE_WIDTH - 1;
         end

         sum = '{0, 0, 0};
         for (int j = 0; j < 3; j++) begin
            c = cc + j - 1;
            for (int i = 0; i < 3; i++) begin
               r = cr + i - 1;
               p = window[j][i];
               if (r < 0 || r >= FRAME_HEIGHT || c < 0 || c >= LINE_WIDTH) p = '0;
               for (int ch = 0; ch < 3; ch++) begin
                  v = int'(p[8*ch +: 8]);
                  t = int'(tmpl_byte[(i*3 + j)*3 + ch]);
                  sum[ch] += (v > t) ? v - t : t - v;
               end
            end
         end

         score = (int'(weight_blue) * sum[0] + int'(weight_green) * sum[1]
                  + int'(weight_red) * sum[2] + 128) >> 8;
         if (score > DIST_CEIL) score = DIST_CEIL;
         if (score < low_mark) low_mark = DIST_W'(score);
         if (score > high_mark) high_mark = DIST_W'(score);

         res.distance      = DIST_W'(score);
         res.frame_min     = low_mark;
         res.frame_max     = high_mark;
         res.last_of_frame = (n == FRAME_ITEMS - 1);
         distance_queue = {distance_queue, res};

         if (res.last_of_frame) begin
            low_mark  = '1;
            high_mark = '0;
         end
      endfunction

      function void check_result(distance_result_type got);
         distance_result_type want;
         results_seen++;
         if (distance_queue.size() == 0) begin
            note_failure($sformatf("unexpected result: distance %0d min %0d max %0d last %0d",
                                   got.distance, got.frame_min, got.frame_max,
                                   got.last_of_frame));
            return;
         end
         want = distance_queue.pop_front();
         if (got.distance !== want.distance || got.frame_min !== want.frame_min ||
             got.frame_max !== want.frame_max || got.last_of_frame !== want.last_of_frame)
            note_failure($sformatf({"result %0d: expected distance %0d min %0d max %0d ",
                                    "last %0d, got distance %0d min %0d max %0d last %0d"},
                                   results_seen, want.distance, want.frame_min,
                                   want.frame_max, want.last_of_frame, got.distance,
                                   got.frame_min, got.frame_max, got.last_of_frame));
      endfunction
   endclass

endpackage

>>> dv/tb_sad_template_distance_3x3.sv
// top of the testbench for sad_template_distance_3x3: the first rows of a frame
// under several template and weight settings, with random gaps and stalls
// depends on sadtd_pkg, sadtd_scoreboard_pkg and the block's rtl
module tb_sad_template_distance_3x3;
   timeunit 1ns;
   timeprecision 1ps;

   import sadtd_pkg::*;
   import sadtd_scoreboard_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_GUARD    = 8;
   localparam int LONG_HOLD      = 400;
   localparam int TAIL_ITEMS     = 110;

   typedef enum int {PIX_UNIFORM, PIX_SATURATED, PIX_BRIGHT, PIX_DARK} pixel_mix_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic [7:0]        req_blue    = '0;
   logic [7:0]        req_green   = '0;
   logic [7:0]        req_red     = '0;
   logic              req_padding = 1'b0;
   logic              rsp_stall   = 1'b0;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [ADDR_W-1:0] paddr       = '0;
   logic [DATA_W-1:0] pwdata      = '0;

   logic              req_stall;
   logic              rsp_valid;
   logic [DIST_W-1:0] rsp_distance;
   logic [DIST_W-1:0] rsp_frame_min;
   logic [DIST_W-1:0] rsp_frame_max;
   logic              rsp_last_of_frame;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   sad_distance_scoreboard sb;
   int unsigned            frame_pos;
   int unsigned            quiet_cycles = 0;
   int                     gap_pct;
   int                     stall_pct;
   bit                     calm;

   sad_template_distance_3x3 i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_blue          (req_blue),
      .req_green         (req_green),
      .req_red           (req_red),
      .req_padding       (req_padding),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .rsp_frame_min     (rsp_frame_min),
      .rsp_frame_max     (rsp_frame_max),
      .rsp_last_of_frame (rsp_last_of_frame),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      distance_result_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{distance: rsp_distance, frame_min: rsp_frame_min,
                     frame_max: rsp_frame_max, last_of_frame: rsp_last_of_frame};
            sb.check_result(seen);
         end
         if (req_valid && !req_stall)
            sb.note_pixel(req_blue, req_green, req_red, req_padding);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: short random stall bursts, two long hold-offs to back up the input
   initial begin : receiver
      int burst;
      int long_holds;
      burst      = 0;
      long_holds = 0;
      forever begin
         @(negedge clock);
         if (burst == 0 && !calm) begin
            if ((long_holds == 0 && sb.results_seen >= 50) ||
                (long_holds == 1 && sb.results_seen >= 400)) begin
               long_holds++;
               burst = LONG_HOLD;
            end else if ($urandom_range(0, 99) < stall_pct) begin
               burst = $urandom_range(1, 6);
            end
         end
         if (burst > 0 && !calm) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
            burst = 0;
         end
      end
   end

   task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red, input logic padding);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_blue    <= blue;
      req_green   <= green;
      req_red     <= red;
      req_padding <= padding;
      do @(posedge clock); while (req_stall);
      frame_pos = (frame_pos + 1 == FRAME_ITEMS) ? 0 : frame_pos + 1;
   endtask

   task automatic hold_input(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic run_items(input int unsigned count, input pixel_mix_type mix);
      logic [7:0] b, g, r;
      logic       pad;
      repeat (count) begin
         if (!calm && $urandom_range(0, 99) < gap_pct) hold_input($urandom_range(1, 6));
         b   = 8'($urandom_range(0, 255));
         g   = 8'($urandom_range(0, 255));
         r   = 8'($urandom_range(0, 255));
         if (frame_pos >= PIXEL_ITEMS) begin
            // flush positions: mostly marked, sometimes unmarked with junk content
            pad = ($urandom_range(0, 3) != 0);
         end else begin
            pad = ($urandom_range(0, 49) == 0);
            case (mix)
               PIX_SATURATED: begin
                  b = {8{b[0]}};
                  g = {8{g[0]}};
                  r = {8{r[0]}};
               end
               PIX_BRIGHT:
                  if ($urandom_range(0, 99) < 97) {b, g, r} = '1;
               PIX_DARK:
                  if ($urandom_range(0, 99) < 97) {b, g, r} = '0;
               default: ;
            endcase
         end
         send_pixel(b, g, r, pad);
      end
   endtask

   task automatic csr_access(input reg_index_type idx, input logic write,
                             input logic [DATA_W-1:0] value, output logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= ADDR_W'({idx, 3'b000});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_register(input reg_index_type idx, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] ignored;
      csr_access(idx, 1'b1, value, ignored);
      sb.write_register(idx, value);
   endtask

   task automatic read_back_registers();
      logic [DATA_W-1:0] data;
      reg_index_type     idx;
      for (int k = int'(REG_TMPL0); k <= int'(REG_WRED); k++) begin
         idx = reg_index_type'(k);
         csr_access(idx, 1'b0, '0, data);
         if (data !== sb.register_value(idx))
            sb.note_failure($sformatf("register %0d read: expected %h, got %h",
                                      idx, sb.register_value(idx), data));
      end
   endtask

   task automatic load_template(input logic [63:0] w0, input logic [63:0] w1,
                                input logic [63:0] w2, input logic [23:0] w3);
      set_register(REG_TMPL0, w0);
      set_register(REG_TMPL1, w1);
      set_register(REG_TMPL2, w2);
      set_register(REG_TMPL3, DATA_W'(w3));
   endtask

   task automatic load_weights(input weight_type wb, input weight_type wg,
                               input weight_type wr);
      set_register(REG_WBLUE, DATA_W'(wb));
      set_register(REG_WGREEN, DATA_W'(wg));
      set_register(REG_WRED, DATA_W'(wr));
      read_back_registers();
   endtask

   task automatic load_random_template();
      load_template({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    24'($urandom));
   endtask

   task automatic load_random_weights();
      load_weights(WEIGHT_W'($urandom_range(0, 1023)), WEIGHT_W'($urandom_range(0, 1023)),
                   WEIGHT_W'($urandom_range(0, 1023)));
   endtask

   // stop feeding until every pending result is out, then let the pipe settle
   task automatic drain();
      hold_input(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_GUARD) @(posedge clock);
   endtask

   initial begin
      sb        = new();
      frame_pos = 0;
      gap_pct   = 10;
      stall_pct = 10;
      calm      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_back_registers();

      // start of frame with default settings: corner and channel extremes
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);   // marked inside the frame: zero pixel
      send_pixel(8'h01, 8'h80, 8'h7F, 1'b0);
      for (int k = 0; k < 8; k++) send_pixel({8{k[0]}}, {8{k[0]}}, {8{k[0]}}, 1'b0);
      run_items(683, PIX_UNIFORM);

      drain();
      load_random_template();
      load_random_weights();
      gap_pct   = 0;
      stall_pct = 20;
      run_items(200, PIX_UNIFORM);

      // zero template, full weights, bright image: distance near its ceiling
      drain();
      load_template('0, '0, '0, '0);
      load_weights('1, '1, '1);
      gap_pct   = 10;
      stall_pct = 10;
      run_items(150, PIX_BRIGHT);

      drain();
      load_template('1, '1, '1, '1);
      gap_pct   = 20;
      stall_pct = 0;
      run_items(150, PIX_DARK);

      drain();
      load_random_template();
      load_weights('0, '0, '0);
      gap_pct   = 10;
      stall_pct = 10;
      run_items(120, PIX_SATURATED);

      drain();
      load_random_template();
      load_weights(WEIGHT_W'(1), WEIGHT_W'(512), WEIGHT_W'(1023));
      run_items(120, PIX_SATURATED);

      drain();
      load_random_template();
      load_random_weights();
      calm = 1'b1;
      run_items(TAIL_ITEMS, PIX_UNIFORM);

      hold_input(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
